>>> src/rhsl_pkg.sv
// rhsl_pkg: shared constants and types for the rgb to hsl pixel converter
// fixed-point scaling, divider geometry and pipeline latency; no dependencies
package rhsl_pkg;

  localparam int HUE_FRAC_BITS = 4;
  localparam int SAT_FRAC_BITS = 12;

  localparam int CH_W  = 8;
  localparam int HUE_W = 13;
  localparam int SAT_W = 13;
  localparam int LIG_W = 9;

  localparam int CH_MAX = 255;

  // one hue sector is 60 degrees
  localparam int HUE_UNIT = 60 * (1 << HUE_FRAC_BITS);
  localparam int HUE_TURN = 6 * HUE_UNIT;

  localparam int HUE_DVD_W = $clog2(CH_MAX * HUE_UNIT + 1);
  localparam int SAT_DVD_W = CH_W + SAT_FRAC_BITS;
  localparam int DIV_W     = (HUE_DVD_W > SAT_DVD_W) ? HUE_DVD_W : SAT_DVD_W;

  // restoring divider, two quotient bits per register stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_PAD_W  = DIV_STAGES * DIV_STEPS;

  localparam int HQ_W   = $clog2(HUE_UNIT + 1);
  localparam int HUE_SW = $clog2(HUE_TURN) + 2;

  // decode stage, dividend stage, divider stages, output stage
  localparam int LATENCY = DIV_STAGES + 3;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic             neg;
    sector_t          sec;
    logic             zero;
    logic [LIG_W-1:0] sum;
  } side_t;

endpackage

>>> src/rgb_to_hsl_pixel.sv
// rgb_to_hsl_pixel: one 8-bit rgb pixel to fixed-point hue, saturation, lightness
// an accepted start is registered through the decode, dividend, divider and output stages to done
// throughput is one item per clock; the depth is set by the two pipelined dividers
// the receiver cannot stall, so busy is high only while rst is applied
// synchronous reset clears every valid bit; no item is in flight after reset
// depends on rhsl_pkg and rhsl_div
module rgb_to_hsl_pixel import rhsl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output logic             done,
  output logic [HUE_W-1:0] hue,
  output logic [SAT_W-1:0] saturation,
  output logic [LIG_W-1:0] lightness
);

  localparam logic signed [HUE_SW-1:0] TURN_S = HUE_SW'(HUE_TURN);

  // decode stage
  logic [CH_W-1:0]       mx;
  logic [CH_W-1:0]       mn;
  sector_t               sec_d;
  logic signed [CH_W:0]  num;
  logic [LIG_W-1:0]      sum_d;
  logic [LIG_W-1:0]      den_full;

  logic                  va;
  logic [CH_W-1:0]       a_mag;
  logic                  a_neg;
  sector_t               a_sec;
  logic [CH_W-1:0]       a_delta;
  logic [LIG_W-1:0]      a_sum;
  logic [CH_W-1:0]       a_den;

  // dividend stage
  logic                  vb;
  logic [DIV_PAD_W-1:0]  b_hue_dvd;
  logic [DIV_PAD_W-1:0]  b_sat_dvd;
  logic [CH_W-1:0]       b_hue_div;
  logic [CH_W-1:0]       b_sat_div;
  side_t                 b_side;

  side_t                 side [DIV_STAGES];

  logic                  hq_valid;
  logic [DIV_PAD_W-1:0]  hq;
  logic [CH_W-1:0]       hr;
  logic                  sq_valid;
  logic [DIV_PAD_W-1:0]  sq;

  logic [HUE_W-1:0]      hue_next;
  logic [SAT_W-1:0]      sat_next;

  assign busy = rst;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    // ties go to red, then green
    if (red >= green && red >= blue) begin
      sec_d = SEC_RED;
      num   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sec_d = SEC_GREEN;
      num   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sec_d = SEC_BLUE;
      num   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    sum_d    = {1'b0, mx} + {1'b0, mn};
    den_full = LIG_W'(2 * CH_MAX) - sum_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start && !busy;
    end
    a_neg   <= num[CH_W];
    a_mag   <= num[CH_W] ? CH_W'(-num) : num[CH_W-1:0];
    a_sec   <= sec_d;
    a_delta <= mx - mn;
    a_sum   <= sum_d;
    a_den   <= (sum_d <= LIG_W'(CH_MAX)) ? sum_d[CH_W-1:0] : den_full[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    b_hue_dvd   <= DIV_PAD_W'(a_mag) * DIV_PAD_W'(HUE_UNIT);
    b_sat_dvd   <= DIV_PAD_W'(a_delta) << SAT_FRAC_BITS;
    b_hue_div   <= a_delta;
    b_sat_div   <= a_den;
    b_side.neg  <= a_neg;
    b_side.sec  <= a_sec;
    b_side.zero <= (a_delta == '0);
    b_side.sum  <= a_sum;
  end

  rhsl_div u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vb),
    .dividend  (b_hue_dvd),
    .divisor   (b_hue_div),
    .out_valid (hq_valid),
    .quotient  (hq),
    .remainder (hr)
  );

  rhsl_div u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vb),
    .dividend  (b_sat_dvd),
    .divisor   (b_sat_div),
    .out_valid (sq_valid),
    .quotient  (sq),
    .remainder ()
  );

  // sideband rides alongside the dividers
  always_ff @(posedge clk) begin
    side[0] <= b_side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side[s] <= side[s-1];
    end
  end

  always_comb begin
    side_t                    se;
    logic [HUE_SW-1:0]        mag_q;
    logic signed [HUE_SW-1:0] h;
    logic signed [HUE_SW-1:0] off;
    se    = side[DIV_STAGES-1];
    mag_q = HUE_SW'(hq[HQ_W-1:0]);
    // floor of a negative quotient rounds the magnitude up
    if (se.neg) begin
      mag_q = mag_q + HUE_SW'(hr != '0);
      h     = -$signed(mag_q);
    end else begin
      h     = $signed(mag_q);
    end
    case (se.sec)
      SEC_RED:   off = '0;
      SEC_GREEN: off = HUE_SW'(2 * HUE_UNIT);
      SEC_BLUE:  off = HUE_SW'(4 * HUE_UNIT);
      default:   off = '0;
    endcase
    h = h + off;
    if (h < 0) begin
      h = h + TURN_S;
    end else if (h >= TURN_S) begin
      h = h - TURN_S;
    end
    hue_next = se.zero ? '0 : HUE_W'(h);
    sat_next = se.zero ? '0 : SAT_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= hq_valid;
    end
    hue        <= hue_next;
    saturation <= sat_next;
    lightness  <= side[DIV_STAGES-1].sum;
  end

  a_div_in_step: assert property (@(posedge clk) disable iff (rst)
    hq_valid == sq_valid)
    else $error("hue and saturation dividers out of step");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted item did not complete");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result with no accepted item");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(hue) < HUE_TURN)
    else $error("hue not below a full turn");

endmodule

>>> src/rhsl_div.sv
// rhsl_div: pipelined restoring divider, DIV_STEPS quotient bits per stage
// unsigned dividend by an 8-bit divisor; depends on rhsl_pkg
module rhsl_div import rhsl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [DIV_PAD_W-1:0] dividend,
  input  logic [CH_W-1:0]      divisor,
  output logic                 out_valid,
  output logic [DIV_PAD_W-1:0] quotient,
  output logic [CH_W-1:0]      remainder
);

  logic                 vld [DIV_STAGES];
  logic [CH_W-1:0]      rem [DIV_STAGES];
  logic [DIV_PAD_W-1:0] dq  [DIV_STAGES];
  logic [CH_W-1:0]      dv  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                 v_in;
    logic [CH_W-1:0]      r_in;
    logic [DIV_PAD_W-1:0] q_in;
    logic [CH_W-1:0]      d_in;
    logic [CH_W-1:0]      rem_next;
    logic [DIV_PAD_W-1:0] dq_next;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = '0;
      assign q_in = dividend;
      assign d_in = divisor;
    end else begin : g_rest
      assign v_in = vld[s-1];
      assign r_in = rem[s-1];
      assign q_in = dq[s-1];
      assign d_in = dv[s-1];
    end

    // dividend bits shift out the top, quotient bits shift in at the bottom
    always_comb begin
      logic [CH_W:0]        t;
      logic [CH_W-1:0]      r;
      logic [DIV_PAD_W-1:0] q;
      r = r_in;
      q = q_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        t = {r, q[DIV_PAD_W-1]};
        if (t >= {1'b0, d_in}) begin
          t = t - {1'b0, d_in};
          q = {q[DIV_PAD_W-2:0], 1'b1};
        end else begin
          q = {q[DIV_PAD_W-2:0], 1'b0};
        end
        r = t[CH_W-1:0];
      end
      rem_next = r;
      dq_next  = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= v_in;
      end
      rem[s] <= rem_next;
      dq[s]  <= dq_next;
      dv[s]  <= d_in;
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = dq[DIV_STAGES-1];
  assign remainder = rem[DIV_STAGES-1];

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##DIV_STAGES out_valid)
    else $error("divider lost an item");

  a_div_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, DIV_STAGES))
    else $error("divider produced an item that never entered");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dv[DIV_STAGES-1] != '0) |-> remainder < dv[DIV_STAGES-1])
    else $error("divider remainder not below divisor");

endmodule

>>> tb/sv/rhsl_checker.sv
// rhsl_checker: predicts hue, saturation and lightness for every accepted pixel
// and compares each done strobe with the oldest prediction; depends on rhsl_pkg
module rhsl_checker import rhsl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  input  logic             done,
  input  logic [HUE_W-1:0] hue,
  input  logic [SAT_W-1:0] saturation,
  input  logic [LIG_W-1:0] lightness,
  output int               mismatch_count,
  output int               pixels_in_flight
);

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [LIG_W-1:0] lightness;
  } hsl_t;

  hsl_t expected_hsl[$];

  function automatic hsl_t hsl_of_rgb(input logic [CH_W-1:0] r, g, b);
    int      rv, gv, bv, hi, lo, span, sum, num, h, sat, den;
    sector_t sec;
    hsl_t    res;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    hi = rv;
    lo = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    span = hi - lo;
    sum  = hi + lo;
    h    = 0;
    sat  = 0;
    if (span != 0) begin
      // ties go to the earlier channel
      if (hi == rv) sec = SEC_RED;
      else if (hi == gv) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED:   num = gv - bv;
        SEC_GREEN: num = bv - rv;
        default:   num = rv - gv;
      endcase
      num = num * HUE_UNIT;
      // floored division, the numerator may be negative
      h = (num >= 0) ? num / span : -((-num + span - 1) / span);
      h = h + 2 * int'(sec) * HUE_UNIT;
      if (h < 0) h = h + HUE_TURN;
      if (h >= HUE_TURN) h = h - HUE_TURN;
      den = (sum <= CH_MAX) ? sum : 2 * CH_MAX - sum;
      sat = (span << SAT_FRAC_BITS) / den;
    end
    res.hue        = h[HUE_W-1:0];
    res.saturation = sat[SAT_W-1:0];
    res.lightness  = sum[LIG_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    hsl_t want;
    int   pushed, popped, bad;
    pushed = 0;
    popped = 0;
    bad    = 0;
    if (rst) begin
      expected_hsl.delete();
      mismatch_count   <= 0;
      pixels_in_flight <= 0;
    end else begin
      if (done) begin
        if (expected_hsl.size() == 0) begin
          $error("result with no item pending: hue %0d sat %0d light %0d",
                 hue, saturation, lightness);
          bad = bad + 1;
        end else begin
          want   = expected_hsl.pop_front();
          popped = 1;
          if (hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, hue);
            bad = bad + 1;
          end
          if (saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation, saturation);
            bad = bad + 1;
          end
          if (lightness !== want.lightness) begin
            $error("lightness: expected %0d, actual %0d", want.lightness, lightness);
            bad = bad + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_hsl.push_back(hsl_of_rgb(red, green, blue));
        pushed = 1;
      end
      mismatch_count   <= mismatch_count + bad;
      pixels_in_flight <= pixels_in_flight + pushed - popped;
    end
  end

endmodule

>>> tb/sv/rgb_to_hsl_pixel_tb.sv
// rgb_to_hsl_pixel_tb: drives corner pixels and random pixel phases into the converter
// depends on rhsl_pkg, rgb_to_hsl_pixel and rhsl_checker
module rgb_to_hsl_pixel_tb import rhsl_pkg::*; ();

  localparam int PHASE_PIXELS = 450;
  localparam int STALL_LIMIT  = 1000;
  localparam int N_CORNERS    = 25;

  // black, white, greys, primaries, ties, hue wrap, one-step deltas, sum boundary
  localparam logic [3*CH_W-1:0] CORNERS [N_CORNERS] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
    24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
    24'hFF0001, 24'hFF00FE, 24'h010000, 24'hFFFEFE, 24'h80807F,
    24'h7F807F, 24'h000100, 24'h000001, 24'hFF8000, 24'h80FF00,
    24'h0080FF, 24'h55AA00, 24'hAA0055, 24'h123456, 24'hFEFFFF
  };

  // idle percentage of the sender in each random phase
  localparam int PHASE_IDLE [4] = '{0, 66, 0, 17};

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  logic [CH_W-1:0]  red   = '0;
  logic [CH_W-1:0]  green = '0;
  logic [CH_W-1:0]  blue  = '0;
  logic             busy;
  logic             done;
  logic [HUE_W-1:0] hue;
  logic [SAT_W-1:0] saturation;
  logic [LIG_W-1:0] lightness;
  int               mismatch_count;
  int               pixels_in_flight;
  int               stall_cycles = 0;

  always #4 clk = ~clk;

  rgb_to_hsl_pixel i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .done       (done),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  rhsl_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .done             (done),
    .hue              (hue),
    .saturation       (saturation),
    .lightness        (lightness),
    .mismatch_count   (mismatch_count),
    .pixels_in_flight (pixels_in_flight)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input int idle_pct);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_pixels();
    start <= 1'b0;
    @(posedge clk);
    while (pixels_in_flight != 0) @(posedge clk);
  endtask

  // mostly uniform colors, with greys, ties and saturated channels mixed in
  task automatic random_pixel(output logic [CH_W-1:0] r, g, b);
    int kind;
    kind = $urandom_range(0, 9);
    r = CH_W'($urandom_range(0, 255));
    g = CH_W'($urandom_range(0, 255));
    b = CH_W'($urandom_range(0, 255));
    case (kind)
      0: begin
        g = r;
        b = r;
      end
      1: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      2: begin
        r = r[0] ? 8'hFF : 8'h00;
        g = g[0] ? 8'hFF : 8'h00;
        b = b[0] ? 8'hFF : 8'h00;
        if ($urandom_range(0, 1) == 1) b = CH_W'($urandom_range(0, 255));
      end
      default: ;
    endcase
  endtask

  initial begin
    logic [CH_W-1:0] r, g, b;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (CORNERS[k])
      send_pixel(CORNERS[k][23:16], CORNERS[k][15:8], CORNERS[k][7:0], 0);
    drain_pixels();
    foreach (PHASE_IDLE[p]) begin
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        random_pixel(r, g, b);
        send_pixel(r, g, b, PHASE_IDLE[p]);
      end
      // sender holds off until every result of the phase is back
      drain_pixels();
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
